// ===== sv/fia_pkg.sv =====
// Shared constants and types for the free interval allocator.
`default_nettype none

package fia_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 32;
    localparam int ENTRY_W       = 2 * ADDR_W;

    typedef logic [1:0] status_t;

    localparam status_t STAT_OK     = 2'd0;
    localparam status_t STAT_NO_FIT = 2'd1;
    localparam status_t STAT_FULL   = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHDN,
        ST_SHUP,
        ST_INSW,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== sv/fia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/free_interval_allocator_core.sv =====
// Top level: best-fit free interval allocator with coalescing.
//
//  channel   signals                          direction  handshake
//  request   start, kind, address, size       in         taken when start & !busy
//  result    done, block_address, status      out        one-cycle strobe on done
//
// A request scans the table (one RAM read per cycle), decides, then may shift the
// tail of the table and write one entry. busy is high throughout, and the next
// word is taken whenever start is high while busy is low.
// Reset clears the entry count; table contents are never read before written.
// busy drops the cycle after done; done cannot stall.
`default_nettype none

module free_interval_allocator_core
    import fia_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              kind,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [ADDR_W-1:0] size,
    output logic                   done,
    output logic      [ADDR_W-1:0] block_address,
    output logic      [1:0]        status
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  nn_reg, nn_next;
    logic [CNT_W-1:0]  rd_reg, rd_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;

    logic              kind_reg, kind_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] rend_reg, rend_next;

    logic              found_reg, found_next;
    logic              lo_reg, lo_next;
    logic              hi_reg, hi_next;
    logic [IDX_W-1:0]  first_reg, first_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic [ADDR_W-1:0] best_reg, best_next;
    logic [ADDR_W-1:0] lo_start_reg, lo_start_next;
    logic [ADDR_W-1:0] hi_end_reg, hi_end_next;
    logic [CNT_W-1:0]  p_reg, p_next;
    logic [CNT_W-1:0]  off_reg, off_next;

    logic [ADDR_W-1:0] block_reg, block_next;
    status_t           status_reg, status_next;

    // RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [ADDR_W-1:0] ent_s, ent_e, ent_len;
    logic [ADDR_W:0]   rend_sum;
    logic [ADDR_W-1:0] new_start;
    logic              alloc_del, free_full, free_empty;
    logic [CNT_W-1:0]  merge_off, rd_m1;
    logic              accept, scan_end, shup_end;

    fia_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept     = start && (state_reg == ST_IDLE);
    assign ent_s      = ram_rdata[ENTRY_W-1:ADDR_W];
    assign ent_e      = ram_rdata[ADDR_W-1:0];
    assign ent_len    = ent_e - ent_s;
    assign rend_sum   = {1'b0, address} + {1'b0, size};
    assign new_start  = lo_start_reg + size_reg;
    assign alloc_del  = (new_start == hi_end_reg);
    assign free_full  = (n_reg == CNT_W'(TABLE_ENTRIES)) && !lo_reg && !hi_reg;
    assign free_empty = (rend_reg == addr_reg);
    assign merge_off  = CNT_W'(last_reg) - CNT_W'(first_reg);
    assign rd_m1      = rd_reg - CNT_W'(1);
    assign scan_end   = (rd_reg == n_reg) && !pend_reg;
    assign shup_end   = (rd_reg == p_reg) && !pend_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    priority if (!found_reg) state_next = ST_DONE;
                    else if (alloc_del)      state_next = ST_SHDN;
                    else                     state_next = ST_DONE;
                end
                else
                begin
                    priority if (free_full)                 state_next = ST_DONE;
                    else if (free_empty)                    state_next = ST_DONE;
                    else if (found_reg && merge_off == '0)  state_next = ST_DONE;
                    else if (found_reg)                     state_next = ST_SHDN;
                    else                                    state_next = ST_SHUP;
                end
            end
            ST_SHDN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHUP:
            begin
                if (shup_end)
                begin
                    state_next = ST_INSW;
                end
            end
            ST_INSW:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        n_next        = n_reg;
        nn_next       = nn_reg;
        rd_next       = rd_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        size_next     = size_reg;
        rend_next     = rend_reg;
        found_next    = found_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        best_next     = best_reg;
        lo_start_next = lo_start_reg;
        hi_end_next   = hi_end_reg;
        p_next        = p_reg;
        off_next      = off_reg;
        block_next    = block_reg;
        status_next   = status_reg;
        ram_we        = 1'b0;
        ram_waddr     = first_reg;
        ram_wdata     = {new_start, hi_end_reg};
        ram_raddr     = rd_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind;
                    addr_next  = address;
                    size_next  = size;
                    rend_next  = rend_sum[ADDR_W] ? {ADDR_W{1'b1}} : rend_sum[ADDR_W-1:0];
                    rd_next    = '0;
                    found_next = 1'b0;
                    lo_next    = 1'b0;
                    hi_next    = 1'b0;
                    p_next     = '0;
                end
            end
            ST_SCAN:
            begin
                if (rd_reg < n_reg)
                begin
                    rd_next   = rd_reg + CNT_W'(1);
                    pend_next = 1'b1;
                    pidx_next = rd_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    if (kind_reg == KIND_ALLOC)
                    begin
                        // strict less-than keeps the lowest index on ties
                        if (ent_len >= size_reg && (!found_reg || ent_len < best_reg))
                        begin
                            found_next    = 1'b1;
                            first_next    = pidx_reg;
                            best_next     = ent_len;
                            lo_start_next = ent_s;
                            hi_end_next   = ent_e;
                        end
                    end
                    else
                    begin
                        if (ent_e == addr_reg)
                        begin
                            lo_next = 1'b1;
                        end
                        if (ent_s == rend_reg)
                        begin
                            hi_next = 1'b1;
                        end
                        // touching or overlapping entries form one contiguous run
                        if (ent_s <= rend_reg && addr_reg <= ent_e)
                        begin
                            if (!found_reg)
                            begin
                                first_next    = pidx_reg;
                                lo_start_next = ent_s;
                            end
                            found_next  = 1'b1;
                            last_next   = pidx_reg;
                            hi_end_next = ent_e;
                        end
                        if (ent_e < addr_reg)
                        begin
                            p_next = p_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_DECIDE:
            begin
                block_next  = '0;
                status_next = STAT_OK;
                nn_next     = n_reg;
                if (kind_reg == KIND_ALLOC)
                begin
                    priority if (!found_reg)
                    begin
                        status_next = STAT_NO_FIT;
                    end
                    else if (alloc_del)
                    begin
                        block_next = lo_start_reg;
                        rd_next    = CNT_W'(first_reg) + CNT_W'(1);
                        off_next   = CNT_W'(1);
                        nn_next    = n_reg - CNT_W'(1);
                    end
                    else
                    begin
                        block_next = lo_start_reg;
                        ram_we     = 1'b1;
                    end
                end
                else
                begin
                    priority if (free_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else if (free_empty)
                    begin
                        status_next = STAT_OK;
                    end
                    else if (found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {(addr_reg < lo_start_reg) ? addr_reg : lo_start_reg,
                                     (rend_reg > hi_end_reg) ? rend_reg : hi_end_reg};
                        rd_next   = CNT_W'(last_reg) + CNT_W'(1);
                        off_next  = merge_off;
                        nn_next   = n_reg - merge_off;
                    end
                    else
                    begin
                        rd_next = n_reg;
                        nn_next = n_reg + CNT_W'(1);
                    end
                end
            end
            ST_SHDN:
            begin
                if (rd_reg < n_reg)
                begin
                    rd_next   = rd_reg + CNT_W'(1);
                    pend_next = 1'b1;
                    pidx_next = rd_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(CNT_W'(pidx_reg) - off_reg);
                    ram_wdata = ram_rdata;
                end
            end
            ST_SHUP:
            begin
                ram_raddr = rd_m1[IDX_W-1:0];
                if (rd_reg > p_reg)
                begin
                    rd_next   = rd_m1;
                    pend_next = 1'b1;
                    pidx_next = rd_m1[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pidx_reg + IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
            end
            ST_INSW:
            begin
                ram_we    = 1'b1;
                ram_waddr = p_reg[IDX_W-1:0];
                ram_wdata = {addr_reg, rend_reg};
            end
            ST_DONE:
            begin
                n_next = nn_reg;
            end
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
            rd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nn_reg       <= nn_next;
        pidx_reg     <= pidx_next;
        kind_reg     <= kind_next;
        addr_reg     <= addr_next;
        size_reg     <= size_next;
        rend_reg     <= rend_next;
        found_reg    <= found_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        best_reg     <= best_next;
        lo_start_reg <= lo_start_next;
        hi_end_reg   <= hi_end_next;
        p_reg        <= p_next;
        off_reg      <= off_next;
        block_reg    <= block_next;
        status_reg   <= status_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = (state_reg == ST_DONE);
    assign block_address = block_reg;
    assign status        = status_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STAT_OK || status == STAT_NO_FIT || status == STAT_FULL))
        else $error("bad status code");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STAT_FULL |-> n_reg == CNT_W'(TABLE_ENTRIES))
        else $error("table-full status with free entries");
`endif

endmodule

`default_nettype wire

// ===== sim/free_interval_allocator_core_tb.sv =====
// Testbench for the free interval allocator: directed table, table fill, then random requests.
`timescale 1ns / 100ps

module free_interval_allocator_core_tb
    import fia_pkg::*;
();

    typedef struct {
        logic [31:0] blk;
        status_t     st;
    } word_t;

    typedef struct {
        logic        kind;
        logic [31:0] addr;
        logic [31:0] len;
        bit          typed;
        logic [31:0] blk;
        status_t     st;
    } row_t;

    typedef struct {
        logic [31:0] addr;
        logic [31:0] len;
    } span_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] size;
    logic              done;
    logic [ADDR_W-1:0] block_address;
    logic [1:0]        status;

    free_interval_allocator_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .address       (address),
        .size          (size),
        .done          (done),
        .block_address (block_address),
        .status        (status)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // free interval table mirror
    logic [31:0] free_lo [TABLE_ENTRIES];
    logic [31:0] free_hi [TABLE_ENTRIES];
    int          free_cnt;

    word_t       result_q [$];
    span_t       owned_q [$];
    int          errors;
    int          idle_cycles;
    bit          no_idle;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void drop_entry(input int k);
        for (int i = k; i + 1 < free_cnt; i++)
        begin
            free_lo[i] = free_lo[i + 1];
            free_hi[i] = free_hi[i + 1];
        end
        free_cnt--;
    endfunction

    function automatic void tidy_table();
        bit          changed;
        int          j;
        logic [31:0] s;
        logic [31:0] e;
        changed = 1'b1;
        for (int i = 0; i < free_cnt;)
        begin
            if (free_hi[i] <= free_lo[i])
                drop_entry(i);
            else
                i++;
        end
        while (changed)
        begin
            changed = 1'b0;
            for (int i = 0; i < free_cnt && !changed; i++)
            begin
                for (int m = i + 1; m < free_cnt && !changed; m++)
                begin
                    if (free_lo[m] <= free_hi[i] && free_lo[i] <= free_hi[m])
                    begin
                        if (free_lo[m] < free_lo[i])
                            free_lo[i] = free_lo[m];
                        if (free_hi[m] > free_hi[i])
                            free_hi[i] = free_hi[m];
                        drop_entry(m);
                        changed = 1'b1;
                    end
                end
            end
        end
        // stable insertion sort by end
        for (int i = 1; i < free_cnt; i++)
        begin
            s = free_lo[i];
            e = free_hi[i];
            j = i;
            while (j > 0 && free_hi[j - 1] > e)
            begin
                free_lo[j] = free_lo[j - 1];
                free_hi[j] = free_hi[j - 1];
                j--;
            end
            free_lo[j] = s;
            free_hi[j] = e;
        end
    endfunction

    function automatic word_t alloc_free_step(input logic k, input logic [31:0] a,
                                              input logic [31:0] s);
        word_t       w;
        int          pick;
        int          lo;
        int          hi;
        logic [31:0] best;
        logic [31:0] len;
        logic [31:0] rend;
        w.blk = '0;
        w.st  = STAT_OK;
        pick  = -1;
        lo    = -1;
        hi    = -1;
        best  = '0;
        if (k == KIND_ALLOC)
        begin
            for (int i = 0; i < free_cnt; i++)
            begin
                len = free_hi[i] - free_lo[i];
                if (len >= s && (pick < 0 || len < best))
                begin
                    pick = i;
                    best = len;
                end
            end
            if (pick < 0)
                w.st = STAT_NO_FIT;
            else
            begin
                w.blk = free_lo[pick];
                free_lo[pick] = free_lo[pick] + s;
                if (free_lo[pick] == free_hi[pick])
                    drop_entry(pick);
                tidy_table();
            end
        end
        else
        begin
            rend = (s > ~a) ? 32'hFFFF_FFFF : a + s;
            for (int i = 0; i < free_cnt; i++)
            begin
                if (free_hi[i] == a)
                    lo = i;
                if (free_lo[i] == rend)
                    hi = i;
            end
            if (lo >= 0 && hi >= 0 && lo != hi)
            begin
                free_hi[lo] = free_hi[hi];
                drop_entry(hi);
                tidy_table();
            end
            else if (lo >= 0)
            begin
                free_hi[lo] = rend;
                tidy_table();
            end
            else if (hi >= 0)
            begin
                free_lo[hi] = a;
                tidy_table();
            end
            else if (free_cnt >= TABLE_ENTRIES)
                w.st = STAT_FULL;
            else
            begin
                free_lo[free_cnt] = a;
                free_hi[free_cnt] = rend;
                free_cnt++;
                tidy_table();
            end
        end
        return w;
    endfunction

    // drive one request; start stays high across back-to-back words
    task automatic send(input logic k, input logic [31:0] a, input logic [31:0] s,
                        input word_t w);
        int gap;
        gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        kind    <= k;
        address <= a;
        size    <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        result_q.push_back(w);
    endtask

    task automatic send_checked(input logic k, input logic [31:0] a, input logic [31:0] s);
        word_t w;
        w = alloc_free_step(k, a, s);
        if (k == KIND_ALLOC && w.st == STAT_OK && s != 0)
            owned_q.push_back('{addr: w.blk, len: s});
        send(k, a, s, w);
    endtask

    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && done)
        begin
            if (result_q.size() == 0)
                report("unexpected word", block_address, 32'h0);
            else
            begin
                w = result_q.pop_front();
                if (block_address !== w.blk)
                    report("block_address", block_address, w.blk);
                if (status !== w.st)
                    report("status", {30'h0, status}, {30'h0, w.st});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 4000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    row_t dir_tab [] = '{
        '{KIND_ALLOC, 32'h0,         32'h0,         1'b1, 32'h0,   STAT_NO_FIT},
        '{KIND_FREE,  32'h100,       32'h100,       1'b1, 32'h0,   STAT_OK},
        '{KIND_ALLOC, 32'h0,         32'h40,        1'b1, 32'h100, STAT_OK},
        '{KIND_ALLOC, 32'hFFFF_FFFF, 32'h0,         1'b1, 32'h140, STAT_OK},
        '{KIND_ALLOC, 32'h0,         32'hFFFF_FFFF, 1'b1, 32'h0,   STAT_NO_FIT},
        '{KIND_FREE,  32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 32'h0,   STAT_OK},
        '{KIND_FREE,  32'h140,       32'h0,         1'b1, 32'h0,   STAT_OK},
        '{KIND_FREE,  32'h100,       32'h40,        1'b1, 32'h0,   STAT_OK},
        '{KIND_FREE,  32'h180,       32'h200,       1'b0, 32'h0,   STAT_OK},
        '{KIND_FREE,  32'h600,       32'h10,        1'b0, 32'h0,   STAT_OK},
        '{KIND_FREE,  32'h380,       32'h280,       1'b0, 32'h0,   STAT_OK},
        '{KIND_ALLOC, 32'h0,         32'h10,        1'b0, 32'h0,   STAT_OK},
        '{KIND_ALLOC, 32'h0,         32'h80,        1'b0, 32'h0,   STAT_OK},
        '{KIND_FREE,  32'h0,         32'h0,         1'b0, 32'h0,   STAT_OK},
        '{KIND_ALLOC, 32'h0,         32'hFF,        1'b0, 32'h0,   STAT_OK},
        '{KIND_FREE,  32'h7FFF_FFFF, 32'h8000_0001, 1'b0, 32'h0,   STAT_OK},
        '{KIND_ALLOC, 32'h0,         32'h8000_0000, 1'b0, 32'h0,   STAT_OK}
    };

    initial
    begin
        word_t       w;
        span_t       sp;
        int          sel;
        int          idx;
        logic [31:0] a;
        logic [31:0] s;

        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_ALLOC;
        address     = '0;
        size        = '0;
        no_idle     = 1'b0;
        free_cnt    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            w = alloc_free_step(dir_tab[i].kind, dir_tab[i].addr, dir_tab[i].len);
            if (dir_tab[i].typed)
            begin
                w.blk = dir_tab[i].blk;
                w.st  = dir_tab[i].st;
            end
            send(dir_tab[i].kind, dir_tab[i].addr, dir_tab[i].len, w);
        end

        // free TABLE_ENTRIES + 2 disjoint ranges so that the table fills and reports full
        for (int i = 0; i < TABLE_ENTRIES + 2; i++)
            send_checked(KIND_FREE, 32'h0010_0000 + i * 32'h100, 32'h10 + i);

        // wait for the block to drain completely
        start <= 1'b0;
        wait (result_q.size() == 0);
        @(posedge clk);

        for (int n = 0; n < 1200; n++)
        begin
            if (n >= 1050)
                no_idle = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h2000)
                                                : $urandom_range(0, 64);
                send_checked(KIND_ALLOC, $urandom, s);
            end
            else if (sel < 70 && owned_q.size() > 0)
            begin
                idx = $urandom_range(0, owned_q.size() - 1);
                sp  = owned_q[idx];
                owned_q.delete(idx);
                send_checked(KIND_FREE, sp.addr, sp.len);
            end
            else if (sel < 92)
            begin
                a = $urandom_range(0, 32'h4000);
                if ($urandom_range(0, 15) == 0)
                    a = a | 32'hFFFF_0000;
                send_checked(KIND_FREE, a, $urandom_range(0, 256));
            end
            else
                send_checked(1'($urandom_range(0, 1)), $urandom, $urandom);
        end

        start <= 1'b0;
        wait (result_q.size() == 0);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
